/* sv/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

  localparam logic [15:0] Repl     = 16'hFFFD;
  localparam logic [19:0] SuppBase = 20'h10000;
  localparam logic [15:0] SurrHi   = 16'hD800;
  localparam logic [15:0] SurrLo   = 16'hDC00;
  localparam logic [5:0]  TrailMsk = 6'h3F;
  localparam int          QDepth   = 4;
  localparam int          QPtrW    = $clog2(QDepth);
  localparam int          QCntW    = $clog2(QDepth + 1);

  // One queued emit command: a single unit, or a surrogate pair built from
  // the 20-bit offset (point - 0x10000).
  typedef struct packed {
    logic        pair;
    logic [19:0] val;   // unit in [15:0] when pair is clear
  } u2u_cmd_t;

endpackage

/* sv/u2u_front.sv */
// Front end: accepts UTF-8 bytes, tracks the open sequence, queues emit commands.
module u2u_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_eoi,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output u2u_pkg::u2u_cmd_t push_cmd
);

  logic [30:0] partial_r, partial_nxt;
  logic [2:0]  trail_r, trail_nxt;
  logic        emit;
  logic [30:0] point;
  logic [30:0] shifted;
  logic [2:0]  trail_dec;
  logic [4:0]  lead_mask;
  logic [2:0]  lead_trail;
  logic        lead_ok;
  logic        acc;

  assign in_ready = ~q_full;
  assign acc      = in_valid & ~q_full;
  assign shifted  = {partial_r[24:0], in_byte[5:0] & u2u_pkg::TrailMsk};
  assign trail_dec = trail_r - 3'd1;

  always_comb begin
    lead_ok    = 1'b1;
    lead_mask  = 5'h00;
    lead_trail = 3'd0;
    if (in_byte[7:5] == 3'b110) begin
      lead_mask = 5'h1F; lead_trail = 3'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_mask = 5'h0F; lead_trail = 3'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_mask = 5'h07; lead_trail = 3'd3;
    end else if (in_byte[7:2] == 6'b111110) begin
      lead_mask = 5'h03; lead_trail = 3'd4;
    end else if (in_byte[7:1] == 7'b1111110) begin
      lead_mask = 5'h01; lead_trail = 3'd5;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    partial_nxt = partial_r;
    trail_nxt   = trail_r;
    emit        = 1'b0;
    point       = {15'd0, u2u_pkg::Repl};
    if (trail_r == 3'd0) begin
      if (!in_byte[7]) begin
        emit  = 1'b1;
        point = {23'd0, in_byte};
      end else if (!lead_ok || in_eoi) begin
        emit        = 1'b1;
        partial_nxt = '0;
        trail_nxt   = 3'd0;
      end else begin
        partial_nxt = {26'd0, in_byte[4:0] & lead_mask};
        trail_nxt   = lead_trail;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      emit        = 1'b1;
      partial_nxt = '0;
      trail_nxt   = 3'd0;
    end else if (trail_dec == 3'd0) begin
      emit        = 1'b1;
      point       = shifted;
      partial_nxt = '0;
      trail_nxt   = 3'd0;
    end else if (in_eoi) begin
      emit        = 1'b1;
      partial_nxt = '0;
      trail_nxt   = 3'd0;
    end else begin
      partial_nxt = shifted;
      trail_nxt   = trail_dec;
    end
  end

  always_comb begin
    push_cmd.pair = |point[30:16];
    if (|point[30:16]) begin
      push_cmd.val = point[19:0] - u2u_pkg::SuppBase;
    end else begin
      push_cmd.val = {4'd0, point[15:0]};
    end
  end

  assign push = acc & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      trail_r   <= 3'd0;
    end else if (acc) begin
      partial_r <= partial_nxt;
      trail_r   <= trail_nxt;
    end
  end

endmodule

/* sv/u2u_fifo.sv */
// Short command queue between front and back ends.
module u2u_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u2u_pkg::u2u_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              nempty,
  output u2u_pkg::u2u_cmd_t head
);

  u2u_pkg::u2u_cmd_t               mem_r [u2u_pkg::QDepth];
  logic [u2u_pkg::QPtrW-1:0]       wp_r, rp_r;
  logic [u2u_pkg::QCntW-1:0]       cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == u2u_pkg::QCntW'(u2u_pkg::QDepth));
  assign nempty  = (cnt_r != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & nempty;
  assign head    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/u2u_back.sv */
// Back end: turns queued commands into UTF-16 units in an output register.
module u2u_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nempty,
  input  u2u_pkg::u2u_cmd_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_unit,
  output logic              out_last
);

  logic        valid_r;
  logic [15:0] unit_r, unit_nxt;
  logic        last_r, last_nxt;
  logic        phase_r, phase_nxt;
  logic        load;

  assign load      = ~valid_r | out_ready;
  assign out_valid = valid_r;
  assign out_unit  = unit_r;
  assign out_last  = last_r;

  always_comb begin
    q_pop     = 1'b0;
    phase_nxt = phase_r;
    unit_nxt  = q_head.val[15:0];
    last_nxt  = 1'b1;
    if (q_head.pair && !phase_r) begin
      // high surrogate first, entry stays for the low half
      unit_nxt  = u2u_pkg::SurrHi + {6'd0, q_head.val[19:10]};
      last_nxt  = 1'b0;
      phase_nxt = load & q_nempty;
    end else begin
      if (q_head.pair) begin
        unit_nxt = u2u_pkg::SurrLo + {6'd0, q_head.val[9:0]};
      end
      q_pop = load & q_nempty;
      if (load && q_nempty) phase_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_nempty) begin
      unit_r <= unit_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) valid_r <= q_nempty;
    end
  end

endmodule

/* sv/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//  Channel | Dir | tdata          | tlast        | Item
//  --------+-----+----------------+--------------+-------------------------
//  in_     | in  | [7:0] in_byte  | end_of_input | one UTF-8 byte
//  out_    | out | [15:0] code_unit | run_last   | one UTF-16 code unit
//
// One byte is taken per cycle while the command queue is not full. A byte
// that completes a sequence or is replaced queues one command; the back end
// turns it into one unit, or into a surrogate pair sent unit by unit through
// the output register, so a pair, built from at least four input bytes,
// does not slow the byte rate. Results go via the queue and output register.
// rst_n (synchronous, active low) clears the sequence state, the four-entry
// command queue and the output register. in_tready drops only when the queue
// is full; a stalled output holds its unit and the queue absorbs the front.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast   // run_last
);

  logic              q_full, q_nempty, q_pop, push;
  u2u_pkg::u2u_cmd_t push_cmd, q_head;

  // Sequence tracking and classification
  u2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_eoi   (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouples byte intake from unit output
  u2u_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  // Unit and surrogate generation
  u2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_unit  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

/* tb/utf8_to_utf16_decoder_test.sv */
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
module utf8_to_utf16_decoder_test;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } byte_item_t;

  typedef struct {
    logic [15:0] unit;
    logic        last;
  } code_unit_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] in_byte
  logic        in_tlast   = 1'b0;   // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [15:0] code_unit
  logic        out_tlast;           // run_last

  // Long receiver hold-off, driven by its own process.
  logic        rx_hold    = 1'b0;

  byte_item_t  bytes_to_send[$];
  code_unit_t  units_due[$];

  // Decoder state mirror.
  logic [30:0] seq_bits = '0;
  logic [2:0]  seq_left = '0;

  int errors     = 0;
  int bytes_sent = 0;
  int units_seen = 0;
  int pairs_due  = 0;
  int repl_due   = 0;

  utf8_to_utf16_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  task automatic due_unit(input logic [15:0] unit, input logic last);
    code_unit_t u;
    u.unit = unit;
    u.last = last;
    units_due.push_back(u);
  endtask

  // Expected units for one accepted byte; updates the state mirror.
  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    logic [2:0]  size;
    logic [7:0]  keep;
    logic [30:0] cp;
    logic [30:0] off;
    logic        bad;
    bad = 1'b0;
    if (seq_left == 3'd0) begin
      // lead byte: size of the form and its payload mask
      casez (b)
        8'b0???????: begin size = 3'd1; keep = 8'h7F; end
        8'b110?????: begin size = 3'd2; keep = 8'h1F; end
        8'b1110????: begin size = 3'd3; keep = 8'h0F; end
        8'b11110???: begin size = 3'd4; keep = 8'h07; end
        8'b111110??: begin size = 3'd5; keep = 8'h03; end
        8'b1111110?: begin size = 3'd6; keep = 8'h01; end
        default:     begin size = 3'd0; keep = 8'h00; end  // stray trailer, FE, FF
      endcase
      if (size == 3'd1) begin
        due_unit({8'h00, b}, 1'b1);
      end else if (size == 3'd0 || eoi) begin
        bad = 1'b1;  // bad lead, or lead cut off by end of input
      end else begin
        seq_bits = {23'd0, b & keep};
        seq_left = size - 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;  // bad trailer is consumed
    end else begin
      seq_bits = {seq_bits[24:0], b[5:0]};
      seq_left = seq_left - 3'd1;
      if (seq_left == 3'd0) begin
        cp = seq_bits;
        seq_bits = '0;
        if (cp < {11'd0, u2u_pkg::SuppBase}) begin
          due_unit(cp[15:0], 1'b1);
        end else begin
          // surrogate pair from the 20 masked bits of the offset
          off = cp - {11'd0, u2u_pkg::SuppBase};
          due_unit(u2u_pkg::SurrHi + {6'd0, off[19:10]}, 1'b0);
          due_unit(u2u_pkg::SurrLo + {6'd0, off[9:0]}, 1'b1);
          pairs_due++;
        end
      end else if (eoi) begin
        bad = 1'b1;  // sequence cut off mid-trailer
      end
    end
    if (bad) begin
      seq_bits = '0;
      seq_left = '0;
      due_unit(u2u_pkg::Repl, 1'b1);
      repl_due++;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eoi);
    byte_item_t it;
    it.b   = b;
    it.eoi = eoi;
    bytes_to_send.push_back(it);
  endtask

  // Wait before the next item: zero in calm stretches, else mostly short.
  function automatic int pick_gap(input logic calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 14);
    return $urandom_range(0, 1);
  endfunction

  // Byte driver: one item from the pending queue, random gap after each.
  byte_item_t tx_cur;
  logic       tx_have = 1'b0;
  logic       tx_calm = 1'b0;
  int         tx_gap  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_have = 1'b0;
      tx_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(tx_cur.b, tx_cur.eoi);
        bytes_sent++;
        tx_have = 1'b0;
        if ($urandom_range(0, 99) == 0) tx_calm = ~tx_calm;
        tx_gap = pick_gap(tx_calm);
      end
      if (!tx_have) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (bytes_to_send.size() != 0) begin
          tx_cur  = bytes_to_send.pop_front();
          tx_have = 1'b1;
        end
      end
      in_tvalid <= tx_have;
      in_tdata  <= tx_cur.b;
      in_tlast  <= tx_cur.eoi;
    end
  end

  // Unit monitor and receiver: check each accepted unit, then maybe stall.
  logic       rx_calm = 1'b0;
  int         rx_wait = 0;
  code_unit_t rx_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        units_seen++;
        if (units_due.size() == 0) begin
          $display("%0t: unexpected unit: expected none, got %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          rx_exp = units_due.pop_front();
          if (out_tdata !== rx_exp.unit) begin
            $display("%0t: code_unit mismatch: expected %h, got %h",
                     $time, rx_exp.unit, out_tdata);
            errors++;
          end
          if (out_tlast !== rx_exp.last) begin
            $display("%0t: run_last mismatch: expected %b, got %b",
                     $time, rx_exp.last, out_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 99) == 0) rx_calm = ~rx_calm;
        rx_wait = pick_gap(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // Two long receiver hold-offs while bytes keep coming: the command queue
  // fills and in_tready must drop.
  initial begin : hold_off
    int thresh;
    for (int k = 0; k < 2; k++) begin
      thresh = (k == 0) ? 400 : 1200;
      while (bytes_sent < thresh) @(posedge clk);
      rx_hold <= 1'b1;
      repeat (250) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  initial begin : watchdog
    #2000000;
    $display("utf8_to_utf16_decoder_test: done, errors");
    $finish;
  end

  initial begin : stim
    int         kind;
    int         len;
    int         ntrail;
    logic       end_here;
    logic [7:0] lead;

    // Directed: ASCII extremes, each form but the 5-byte one, every bad-byte
    // case, end-of-input cases (lead or trailer cut off, final-byte completion).
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b1);
    queue_byte(8'hF0, 1'b0); queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);  // stray trailer
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);  // bad trailer, consumed
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);  // cut off mid-trailer
    queue_byte(8'hC3, 1'b1);                           // lone lead at end
    queue_byte(8'hFD, 1'b0);                           // largest 6-byte point
    for (int i = 0; i < 5; i++) queue_byte(8'hBF, 1'b0);

    // Random: mostly well-formed sequences, some broken ones and noise.
    while (bytes_to_send.size() < 1725) begin
      kind     = $urandom_range(0, 99);
      end_here = ($urandom_range(0, 11) == 0);
      if (kind < 30) begin
        queue_byte(8'($urandom_range(0, 127)), end_here);
      end else if (kind < 88) begin
        if (kind < 80) begin
          len = (kind < 45) ? 2 : (kind < 58) ? 3 : (kind < 72) ? 4 :
                (kind < 76) ? 5 : 6;
          ntrail = len - 1;
        end else begin
          // truncated: the next byte lands where a trailer was due
          len    = $urandom_range(2, 6);
          ntrail = $urandom_range(0, len - 2);
        end
        lead = 8'((8'hFF << (8 - len)) | ($urandom & (8'hFF >> (len + 1))));
        for (int i = 0; i <= ntrail; i++)
          queue_byte((i == 0) ? lead : {2'b10, 6'($urandom)},
                     end_here && (i == ntrail));
      end else if (kind < 93) begin
        queue_byte({2'b10, 6'($urandom)}, end_here);
      end else if (kind < 96) begin
        queue_byte({7'h7F, 1'($urandom)}, end_here);
      end else begin
        queue_byte(8'($urandom), end_here);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (units_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);  // catch any extra unit

    $display("Sent %0d UTF-8 bytes, checked %0d UTF-16 units", bytes_sent, units_seen);
    $display("including %0d surrogate pairs and %0d replacement units",
             pairs_due, repl_due);
    if (errors == 0)
      $display("utf8_to_utf16_decoder_test: done, clean");
    else
      $display("utf8_to_utf16_decoder_test: done, errors");
    $finish;
  end

endmodule

/* utf8_to_utf16_decoder.f */
sv/u2u_pkg.sv
sv/u2u_front.sv
sv/u2u_fifo.sv
sv/u2u_back.sv
sv/utf8_to_utf16_decoder.sv
tb/utf8_to_utf16_decoder_test.sv
